>>> src/ctp_pkg.sv
// Shared constants, types and job record for the CAN-TP reassembler.
package ctp_pkg;

   localparam int MAX_LENGTH_BITS = 12;
   localparam int LEN_W           = MAX_LENGTH_BITS;
   localparam int POS_W           = 12;
   localparam int BYTES_PER_JOB   = 7;
   localparam int COUNT_W         = 3;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_REARM = 1'b1;

   localparam logic [7:0] PCI_LOW_MASK = 8'h0F;
   localparam logic [COUNT_W-1:0] SF_MAX_LEN   = 3'd7;
   localparam logic [COUNT_W-1:0] FF_DATA_LEN  = 3'd6;
   localparam logic [COUNT_W-1:0] CF_DATA_LEN  = 3'd7;

   typedef enum logic [3:0] {
      KIND_SINGLE = 4'h0,
      KIND_FIRST  = 4'h1,
      KIND_CONSEC = 4'h2
   } ctp_kind_type;

   // One processed frame: bytes to emit, their start position and the frame's status.
   typedef struct packed {
      logic [BYTES_PER_JOB-1:0][7:0] data;
      logic [COUNT_W-1:0]            count;
      logic [LEN_W-1:0]              base;
      logic [LEN_W-1:0]              msg_len;
      logic                          done;
   } ctp_job_type;

endpackage

>>> src/ctp_req_if.sv
// Request channel: one received CAN frame or a rearm.
interface ctp_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic       frame_ok;
   logic [7:0] byte0;
   logic [7:0] byte1;
   logic [7:0] byte2;
   logic [7:0] byte3;
   logic [7:0] byte4;
   logic [7:0] byte5;
   logic [7:0] byte6;
   logic [7:0] byte7;

   modport source (output valid, req_type, frame_ok, byte0, byte1, byte2, byte3,
                   byte4, byte5, byte6, byte7, input ready);
   modport sink (input valid, req_type, frame_ok, byte0, byte1, byte2, byte3,
                 byte4, byte5, byte6, byte7, output ready);
endinterface

>>> src/ctp_rsp_if.sv
// Response channel: one reassembled payload byte or a status result.
interface ctp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        byte_valid;
   logic [11:0] position;
   logic [11:0] message_length;
   logic        complete;
   logic        last;

   modport source (output valid, data_byte, byte_valid, position, message_length,
                   complete, last, input ready);
   modport sink (input valid, data_byte, byte_valid, position, message_length,
                 complete, last, output ready);
endinterface

>>> src/ctp_front.sv
// Front end: accepts requests, tracks reassembly state, builds one job per processed frame.
module ctp_front (
   input  logic               clock,
   input  logic               reset,
   ctp_req_if.sink            req_ch,
   output logic               job_push,
   output ctp_pkg::ctp_job_type job,
   input  logic               job_ready
);
   import ctp_pkg::*;

   logic [LEN_W-1:0] ann_len_ff, ann_len_in;
   logic [LEN_W-1:0] rcv_cnt_ff, rcv_cnt_in;
   logic [LEN_W-1:0] wr_pos_ff, wr_pos_in;
   logic [11:0]      remain_ff, remain_in;
   logic             locked_ff, locked_in;

   logic             accept;
   logic             process;
   logic [3:0]       pci_len;
   logic [11:0]      ff_len;
   ctp_kind_type     kind;
   logic [COUNT_W-1:0] n;
   logic [LEN_W-1:0] ann_new;
   logic [LEN_W-1:0] rcv_new;
   logic [LEN_W-1:0] wr_new;
   logic [11:0]      remain_new;
   logic [LEN_W-1:0] base;
   logic [BYTES_PER_JOB-1:0][7:0] data;
   logic             done;

   assign req_ch.ready = job_ready;
   assign accept  = req_ch.valid && req_ch.ready;
   assign process = accept && (req_ch.req_type == REQ_FRAME) && req_ch.frame_ok &&
                    !locked_ff;
   assign pci_len = 4'(req_ch.byte0 & PCI_LOW_MASK);
   assign ff_len  = {pci_len, req_ch.byte1};
   assign kind    = ctp_kind_type'(req_ch.byte0[7:4]);

   always_comb begin
      n          = '0;
      base       = wr_pos_ff;
      ann_new    = ann_len_ff;
      remain_new = remain_ff;
      data       = {req_ch.byte7, req_ch.byte6, req_ch.byte5, req_ch.byte4,
                    req_ch.byte3, req_ch.byte2, req_ch.byte1};
      unique case (kind)
         KIND_SINGLE: begin
            ann_new = LEN_W'(pci_len);
            base    = '0;
            if (pci_len <= 4'(SF_MAX_LEN)) begin
               n = COUNT_W'(pci_len);
            end
         end
         KIND_FIRST: begin
            ann_new    = LEN_W'(ff_len);
            n          = FF_DATA_LEN;
            data       = {8'h00, req_ch.byte7, req_ch.byte6, req_ch.byte5,
                          req_ch.byte4, req_ch.byte3, req_ch.byte2};
            remain_new = (ff_len > 12'(FF_DATA_LEN)) ? ff_len - 12'(FF_DATA_LEN) : '0;
         end
         KIND_CONSEC: begin
            // take at most one frame's worth, stop when the message is satisfied
            n          = (remain_ff >= 12'(CF_DATA_LEN)) ? CF_DATA_LEN
                                                         : COUNT_W'(remain_ff);
            remain_new = remain_ff - 12'(n);
         end
         default: begin
            n = '0;
         end
      endcase
      rcv_new = rcv_cnt_ff + LEN_W'(n);
      wr_new  = (kind == KIND_SINGLE) ? wr_pos_ff : wr_pos_ff + LEN_W'(n);
      done    = (ann_new == rcv_new);

      ann_len_in = ann_len_ff;
      rcv_cnt_in = rcv_cnt_ff;
      wr_pos_in  = wr_pos_ff;
      remain_in  = remain_ff;
      locked_in  = locked_ff;
      if (accept && (req_ch.req_type == REQ_REARM)) begin
         locked_in = 1'b0;
      end else if (process) begin
         ann_len_in = ann_new;
         remain_in  = remain_new;
         // clear counters and lock once the message is whole
         rcv_cnt_in = done ? '0 : rcv_new;
         wr_pos_in  = done ? '0 : wr_new;
         locked_in  = done;
      end
   end

   assign job_push    = process;
   assign job.data    = data;
   assign job.count   = n;
   assign job.base    = base;
   assign job.msg_len = ann_new;
   assign job.done    = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         ann_len_ff <= '0;
         rcv_cnt_ff <= '0;
         wr_pos_ff  <= '0;
         remain_ff  <= '0;
         locked_ff  <= 1'b0;
      end else begin
         ann_len_ff <= ann_len_in;
         rcv_cnt_ff <= rcv_cnt_in;
         wr_pos_ff  <= wr_pos_in;
         remain_ff  <= remain_in;
         locked_ff  <= locked_in;
      end
   end
endmodule

>>> src/ctp_queue.sv
// Short job queue between the front end and the byte emitter.
module ctp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ctp_pkg::ctp_job_type push_job,
   output logic                 not_full,
   input  logic                 pop,
   output logic                 head_valid,
   output ctp_pkg::ctp_job_type head_job
);
   import ctp_pkg::*;

   ctp_job_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign not_full   = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && not_full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

>>> src/ctp_back.sv
// Back end: walks the queued job and emits one response per cycle while the receiver is ready, into an output register.
module ctp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  ctp_pkg::ctp_job_type job,
   output logic                 job_pop,
   ctp_rsp_if.source            rsp_ch
);
   import ctp_pkg::*;

   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               valid_ff, valid_in;
   logic [7:0]         data_ff, data_in;
   logic               bvalid_ff, bvalid_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   len_ff, len_in;
   logic               complete_ff, complete_in;
   logic               last_ff, last_in;

   logic               load;
   logic               has_bytes;
   logic [COUNT_W-1:0] last_idx;
   logic               is_last;
   logic [LEN_W-1:0]   pos_sum;

   assign load      = job_valid && (!valid_ff || rsp_ch.ready);
   assign has_bytes = (job.count != '0);
   assign last_idx  = has_bytes ? job.count - 1'b1 : '0;
   assign is_last   = (idx_ff == last_idx);
   assign pos_sum   = job.base + LEN_W'(idx_ff);
   assign job_pop   = load && is_last;

   always_comb begin
      idx_in      = idx_ff;
      valid_in    = valid_ff;
      data_in     = data_ff;
      bvalid_in   = bvalid_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      complete_in = complete_ff;
      last_in     = last_ff;
      if (load) begin
         valid_in    = 1'b1;
         idx_in      = is_last ? '0 : idx_ff + 1'b1;
         bvalid_in   = has_bytes;
         data_in     = has_bytes ? job.data[idx_ff] : 8'h00;
         pos_in      = has_bytes ? POS_W'(pos_sum) : '0;
         len_in      = POS_W'(job.msg_len);
         complete_in = is_last && job.done;
         last_in     = is_last;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.data_byte      = data_ff;
   assign rsp_ch.byte_valid     = bvalid_ff;
   assign rsp_ch.position       = pos_ff;
   assign rsp_ch.message_length = len_ff;
   assign rsp_ch.complete       = complete_ff;
   assign rsp_ch.last           = last_ff;

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      bvalid_ff   <= bvalid_in;
      pos_ff      <= pos_in;
      len_ff      <= len_in;
      complete_ff <= complete_in;
      last_ff     <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end
endmodule

>>> src/can_tp_reassembler.sv
// Top level of the CAN-TP receive reassembler.
// req_ch carries one received 8-byte CAN frame (req_type 0) or a rearm (req_type 1).
// Frames are processed only when frame_ok is set and the block is not locked;
// single, first and consecutive frames are reassembled, other types give status only.
// rsp_ch carries one result per stored byte (data_byte at position), or a single
// status result when a processed frame stores nothing; last marks the final result
// of a frame and complete marks the frame that finished the message.
// Rearms and ignored frames produce no result.
// The first result of a frame passes through the job queue and then the output register.
// The byte emitter works through a frame one result at a time, one per stored byte or
// a single status result; requests are taken every cycle while the
// two-entry job queue has room.
// A stalled receiver holds the output register; the queue fills and then req_ch.ready
// drops until the emitter drains a job.
// Reset clears the reassembly counters, the lock, the queue and the output valid.
module can_tp_reassembler (
   input  logic      clock,
   input  logic      reset,
   ctp_req_if.sink   req_ch,
   ctp_rsp_if.source rsp_ch
);
   import ctp_pkg::*;

   logic        job_push;
   ctp_job_type push_job;
   logic        job_ready;
   logic        job_pop;
   logic        head_valid;
   ctp_job_type head_job;

   ctp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .job_push  (job_push),
      .job       (push_job),
      .job_ready (job_ready)
   );

   ctp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .not_full   (job_ready),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   ctp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .job_pop   (job_pop),
      .rsp_ch    (rsp_ch)
   );

   a_reset_idle: assert property (@(posedge clock) $past(reset) |-> !rsp_ch.valid)
      else $error("response valid right after reset");

   a_complete_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.complete |-> rsp_ch.last)
      else $error("complete on a result that is not the last of its frame");

   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.byte_valid |->
         rsp_ch.last && (rsp_ch.position == '0) && (rsp_ch.data_byte == '0))
      else $error("status result not alone or not cleared");

   a_pop_has_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> head_valid && !(job_push && !job_ready))
      else $error("job queue pop without a job or push into a full queue");
endmodule
